// ===== rtl/core/sasr_pkg.sv =====
`default_nettype none
// ============================================================================
// sasr_pkg
// Shared widths, codes and record types of the servo slew ramp sequencer.
// ============================================================================
package sasr_pkg;

    localparam int CHAN_W        = 4;
    localparam int CHANNEL_COUNT = 16;
    localparam int PULSE_BITS    = 12;
    localparam int ANGLE_W       = 9;
    localparam int STEP_W        = 16;
    localparam int TICK_W        = 10;

    localparam int DIVIDEND_W = ANGLE_W + PULSE_BITS;
    localparam int DIVISOR_W  = TICK_W;

    localparam int PULSE_LIMIT = (1 << PULSE_BITS) - 1;
    localparam int CONT_MIDDLE = 395;
    localparam logic [PULSE_BITS-1:0] CONT_MIDDLE_PULSE = (CONT_MIDDLE > PULSE_LIMIT) ?
        PULSE_BITS'(PULSE_LIMIT) : PULSE_BITS'(CONT_MIDDLE);
    localparam logic [TICK_W-1:0] TICK_PERIOD_RESET = TICK_W'(10);

    typedef enum logic [1:0] {
        REQ_CALIBRATE = 2'd0,
        REQ_PRESET    = 2'd1,
        REQ_MOVE      = 2'd2,
        REQ_TICK      = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_BUSY = 2'd1,
        STATUS_SPAN = 2'd2,
        STATUS_DONE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PRESET_MIN  = 2'd0,
        PRESET_MID  = 2'd1,
        PRESET_MAX  = 2'd2,
        PRESET_NONE = 2'd3
    } preset_t;

    typedef struct packed {
        logic                  cont;
        logic [ANGLE_W-1:0]    angle_high;
        logic [ANGLE_W-1:0]    angle_low;
        logic [PULSE_BITS-1:0] pulse_high;
        logic [PULSE_BITS-1:0] pulse_low;
    } cal_entry_t;

    typedef struct packed {
        status_t               status;
        logic                  write_valid;
        logic [CHAN_W-1:0]     write_channel;
        logic [PULSE_BITS-1:0] write_value;
        logic                  busy;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/sasr_if.sv =====
`default_nettype none
// ============================================================================
// sasr_if
// Command and result channels of the servo slew ramp sequencer.
// ============================================================================
interface sasr_cmd_if
    import sasr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [1:0]            req_type;
    logic [CHAN_W-1:0]     channel;
    logic [PULSE_BITS-1:0] pulse_min;
    logic [PULSE_BITS-1:0] pulse_max;
    logic [ANGLE_W-1:0]    angle_min;
    logic [ANGLE_W-1:0]    angle_max;
    logic                  continuous_rotation;
    logic [1:0]            preset_select;
    logic [ANGLE_W-1:0]    target_angle;
    logic [STEP_W-1:0]     step_ms;

    modport source (
        output valid, req_type, channel, pulse_min, pulse_max, angle_min, angle_max,
               continuous_rotation, preset_select, target_angle, step_ms,
        input  ready
    );

    modport sink (
        input  valid, req_type, channel, pulse_min, pulse_max, angle_min, angle_max,
               continuous_rotation, preset_select, target_angle, step_ms,
        output ready
    );
endinterface

interface sasr_res_if
    import sasr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic                  write_valid;
    logic [CHAN_W-1:0]     write_channel;
    logic [PULSE_BITS-1:0] write_value;
    logic                  busy_res;

    modport source (
        output valid, status, write_valid, write_channel, write_value, busy_res,
        input  ready
    );

    modport sink (
        input  valid, status, write_valid, write_channel, write_value, busy_res,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/core/sasr_div.sv =====
`default_nettype none
// ============================================================================
// sasr_div
// Unsigned restoring divider that retires one quotient bit per cycle.
// ============================================================================
module sasr_div
    import sasr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);
    localparam int COUNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = COUNT_W'(DIVIDEND_W);
            quo_next   = dividend;
            dvs_next   = divisor;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            quo_next   = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next   = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            count_next = count_reg - COUNT_W'(1);
            if (count_reg == COUNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ===== rtl/core/servo_angle_slew_ramp.sv =====
`default_nettype none
// ============================================================================
// servo_angle_slew_ramp
// Multi-channel servo pulse sequencer with a linear angle map and slew ramp.
// ============================================================================
// The block handles one command transaction at a time and returns exactly one
// result transaction for each. For calibration, preset, tick and refused
// commands the calibration and position memories are read at the accepting
// edge, the execute state decides and writes back, and the output state loads
// the output register once no earlier result is still waiting to be taken. An
// accepted move runs the shared restoring divider twice, with one quotient bit
// per cycle, first for the angle map and then for the step period. A move whose
// target equals the current position skips the second division. Per-channel
// state is held in two single-port memories whose entries read as zero until
// written, so no clearing pass follows reset. The tick period register may only
// be written while no transaction is in flight.
module servo_angle_slew_ramp
    import sasr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    sasr_cmd_if.sink               cmd,
    sasr_res_if.source             res,
    input  wire logic              cfg_wr_en,
    input  wire logic [TICK_W-1:0] cfg_wr_data
);
    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EXEC    = 6'b000010,
        S_MAPDIV  = 6'b000100,
        S_TARGET  = 6'b001000,
        S_STEPDIV = 6'b010000,
        S_OUT     = 6'b100000
    } state_t;

    function automatic result_t make_result(
        status_t               st,
        logic                  wr,
        logic [CHAN_W-1:0]     ch,
        logic [PULSE_BITS-1:0] val,
        logic                  busy
    );
        result_t r;
        r.status        = st;
        r.write_valid   = wr;
        r.write_channel = wr ? ch : '0;
        r.write_value   = wr ? val : '0;
        r.busy          = busy;
        return r;
    endfunction

    state_t                state_reg, state_next;
    logic [TICK_W-1:0]     tick_period_reg;
    logic                  move_active_reg, move_active_next;
    logic [CHAN_W-1:0]     move_channel_reg, move_channel_next;
    logic [PULSE_BITS-1:0] move_target_reg, move_target_next;
    logic [STEP_W-1:0]     step_period_reg, step_period_next;
    logic [STEP_W-1:0]     wait_reg, wait_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_load;

    req_kind_t             req_reg;
    logic [CHAN_W-1:0]     chan_reg;
    logic [PULSE_BITS-1:0] pulse_min_reg;
    logic [PULSE_BITS-1:0] pulse_max_reg;
    logic [ANGLE_W-1:0]    angle_min_reg;
    logic [ANGLE_W-1:0]    angle_max_reg;
    logic                  cont_reg;
    preset_t               preset_reg;
    logic [ANGLE_W-1:0]    angle_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  map_neg_reg, map_neg_next;
    logic [PULSE_BITS-1:0] target_reg, target_next;
    result_t               result_reg, result_next;
    result_t               out_reg;

    cal_entry_t            cal_mem [CHANNEL_COUNT];
    logic [PULSE_BITS-1:0] pos_mem [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] cal_valid_reg;
    logic [CHANNEL_COUNT-1:0] pos_valid_reg;
    cal_entry_t            cal_rd_reg;
    logic [PULSE_BITS-1:0] pos_rd_reg;
    logic                  cal_rd_valid_reg;
    logic                  pos_rd_valid_reg;
    logic [CHAN_W-1:0]     pos_rd_addr;
    logic                  cal_we;
    cal_entry_t            cal_wr_data;
    logic                  pos_we;
    logic [CHAN_W-1:0]     pos_wr_addr;
    logic [PULSE_BITS-1:0] pos_wr_data;

    cal_entry_t            cal_cur;
    logic [PULSE_BITS-1:0] pos_cur;
    logic                  cmd_fire;
    logic                  chan_in_range;
    logic [STEP_W-1:0]     wait_dec;
    logic [PULSE_BITS-1:0] pos_step;
    logic [PULSE_BITS-1:0] mid_pulse;
    logic [ANGLE_W-1:0]    ang_mag;
    logic [PULSE_BITS-1:0] pul_mag;
    logic [ANGLE_W-1:0]    span_mag;
    logic                  ang_neg;
    logic                  pul_neg;
    logic                  span_neg;
    logic [DIVIDEND_W-1:0] map_product;
    logic [TICK_W-1:0]     tick_eff;
    logic [DIVIDEND_W:0]   tgt_sum;
    logic [PULSE_BITS-1:0] tgt_clamped;
    logic [STEP_W-1:0]     period_q;

    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quotient;

    sasr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign cmd_fire    = cmd.valid && cmd.ready;
    assign cmd.ready   = (state_reg == S_IDLE);
    assign pos_rd_addr = (req_kind_t'(cmd.req_type) == REQ_TICK) ? move_channel_reg : cmd.channel;

    assign cal_cur = cal_rd_valid_reg ? cal_rd_reg : '0;
    assign pos_cur = pos_rd_valid_reg ? pos_rd_reg : '0;

    assign chan_in_range = {1'b0, chan_reg} < (CHAN_W + 1)'(CHANNEL_COUNT);
    assign wait_dec      = (wait_reg != '0) ? wait_reg - STEP_W'(1) : '0;
    assign pos_step      = (pos_cur < move_target_reg) ? pos_cur + PULSE_BITS'(1)
                                                       : pos_cur - PULSE_BITS'(1);

    assign mid_pulse = (cal_cur.pulse_high >= cal_cur.pulse_low) ?
        cal_cur.pulse_low + ((cal_cur.pulse_high - cal_cur.pulse_low) >> 1) :
        cal_cur.pulse_low - ((cal_cur.pulse_low - cal_cur.pulse_high) >> 1);

    assign ang_neg  = angle_reg < cal_cur.angle_low;
    assign ang_mag  = ang_neg ? cal_cur.angle_low - angle_reg : angle_reg - cal_cur.angle_low;
    assign pul_neg  = cal_cur.pulse_high < cal_cur.pulse_low;
    assign pul_mag  = pul_neg ? cal_cur.pulse_low - cal_cur.pulse_high
                              : cal_cur.pulse_high - cal_cur.pulse_low;
    assign span_neg = cal_cur.angle_high < cal_cur.angle_low;
    assign span_mag = span_neg ? cal_cur.angle_low - cal_cur.angle_high
                               : cal_cur.angle_high - cal_cur.angle_low;
    assign map_product = DIVIDEND_W'(ang_mag) * DIVIDEND_W'(pul_mag);

    assign tick_eff = (tick_period_reg == '0) ? TICK_W'(1) : tick_period_reg;

    assign tgt_sum = {1'b0, div_quotient} + (DIVIDEND_W + 1)'(cal_cur.pulse_low);
    always_comb
    begin
        if (map_neg_reg)
        begin
            if (div_quotient > DIVIDEND_W'(cal_cur.pulse_low))
            begin
                tgt_clamped = '0;
            end
            else
            begin
                tgt_clamped = cal_cur.pulse_low - div_quotient[PULSE_BITS-1:0];
            end
        end
        else if (tgt_sum > (DIVIDEND_W + 1)'(PULSE_LIMIT))
        begin
            tgt_clamped = PULSE_BITS'(PULSE_LIMIT);
        end
        else
        begin
            tgt_clamped = tgt_sum[PULSE_BITS-1:0];
        end
    end

    assign period_q = (div_quotient[STEP_W-1:0] == '0) ? STEP_W'(1) : div_quotient[STEP_W-1:0];

    assign cal_wr_data = '{
        cont:       cont_reg,
        angle_high: angle_max_reg,
        angle_low:  angle_min_reg,
        pulse_high: pulse_max_reg,
        pulse_low:  pulse_min_reg
    };

    always_comb
    begin
        state_next        = state_reg;
        move_active_next  = move_active_reg;
        move_channel_next = move_channel_reg;
        move_target_next  = move_target_reg;
        step_period_next  = step_period_reg;
        wait_next         = wait_reg;
        map_neg_next      = map_neg_reg;
        target_next       = target_reg;
        result_next       = result_reg;
        cal_we            = 1'b0;
        pos_we            = 1'b0;
        pos_wr_addr       = chan_reg;
        pos_wr_data       = pos_step;
        div_start         = 1'b0;
        div_dividend      = map_product;
        div_divisor       = DIVISOR_W'(span_mag);
        out_load          = 1'b0;
        out_valid_next    = out_valid_reg && !res.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_OUT;
                if (req_reg == REQ_TICK)
                begin
                    if (!move_active_reg)
                    begin
                        result_next = make_result(STATUS_OK, 1'b0, '0, '0, 1'b0);
                    end
                    else if (wait_dec != '0)
                    begin
                        wait_next   = wait_dec;
                        result_next = make_result(STATUS_OK, 1'b0, '0, '0, 1'b1);
                    end
                    else if (pos_cur == move_target_reg)
                    begin
                        wait_next        = '0;
                        move_active_next = 1'b0;
                        result_next      = make_result(STATUS_DONE, 1'b0, '0, '0, 1'b0);
                    end
                    else
                    begin
                        pos_we      = 1'b1;
                        pos_wr_addr = move_channel_reg;
                        pos_wr_data = pos_step;
                        wait_next   = step_period_reg;
                        result_next = make_result(STATUS_OK, 1'b1, move_channel_reg, pos_step,
                                                  1'b1);
                    end
                end
                else if (move_active_reg)
                begin
                    result_next = make_result(STATUS_BUSY, 1'b0, '0, '0, 1'b1);
                end
                else if (!chan_in_range)
                begin
                    result_next = make_result(STATUS_OK, 1'b0, '0, '0, 1'b0);
                end
                else
                begin
                    case (req_reg)
                        REQ_CALIBRATE:
                        begin
                            cal_we      = 1'b1;
                            result_next = make_result(STATUS_OK, 1'b0, '0, '0, 1'b0);
                        end

                        REQ_PRESET:
                        begin
                            pos_we = 1'b1;
                            case (preset_reg)
                                PRESET_MIN: pos_wr_data = cal_cur.pulse_low;
                                PRESET_MAX: pos_wr_data = cal_cur.pulse_high;
                                PRESET_MID: pos_wr_data = cal_cur.cont ? CONT_MIDDLE_PULSE
                                                                       : mid_pulse;
                                default:    pos_we = 1'b0;
                            endcase
                            result_next = make_result(STATUS_OK, pos_we, chan_reg, pos_wr_data,
                                                      1'b0);
                        end

                        REQ_MOVE:
                        begin
                            if (span_mag == '0)
                            begin
                                result_next = make_result(STATUS_SPAN, 1'b0, '0, '0, 1'b0);
                            end
                            else
                            begin
                                div_start    = 1'b1;
                                map_neg_next = ang_neg ^ pul_neg ^ span_neg;
                                state_next   = S_MAPDIV;
                            end
                        end

                        default:
                        begin
                            result_next = make_result(STATUS_OK, 1'b0, '0, '0, 1'b0);
                        end
                    endcase
                end
            end

            S_MAPDIV:
            begin
                if (div_done)
                begin
                    target_next = tgt_clamped;
                    state_next  = S_TARGET;
                end
            end

            S_TARGET:
            begin
                if (target_reg == pos_cur)
                begin
                    result_next = make_result(STATUS_OK, 1'b0, '0, '0, 1'b0);
                    state_next  = S_OUT;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = DIVIDEND_W'(step_reg);
                    div_divisor  = DIVISOR_W'(tick_eff);
                    state_next   = S_STEPDIV;
                end
            end

            S_STEPDIV:
            begin
                if (div_done)
                begin
                    move_active_next  = 1'b1;
                    move_channel_next = chan_reg;
                    move_target_next  = target_reg;
                    step_period_next  = period_q;
                    wait_next         = period_q;
                    result_next       = make_result(STATUS_OK, 1'b1, chan_reg, pos_cur, 1'b1);
                    state_next        = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            tick_period_reg  <= TICK_PERIOD_RESET;
            move_active_reg  <= 1'b0;
            move_channel_reg <= '0;
            move_target_reg  <= '0;
            step_period_reg  <= '0;
            wait_reg         <= '0;
            out_valid_reg    <= 1'b0;
            cal_valid_reg    <= '0;
            pos_valid_reg    <= '0;
            cal_rd_valid_reg <= 1'b0;
            pos_rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            move_active_reg  <= move_active_next;
            move_channel_reg <= move_channel_next;
            move_target_reg  <= move_target_next;
            step_period_reg  <= step_period_next;
            wait_reg         <= wait_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_wr_en)
            begin
                tick_period_reg <= cfg_wr_data;
            end
            if (cmd_fire)
            begin
                cal_rd_valid_reg <= cal_valid_reg[cmd.channel];
                pos_rd_valid_reg <= pos_valid_reg[pos_rd_addr];
            end
            if (cal_we)
            begin
                cal_valid_reg[chan_reg] <= 1'b1;
            end
            if (pos_we)
            begin
                pos_valid_reg[pos_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            cal_rd_reg <= cal_mem[cmd.channel];
            pos_rd_reg <= pos_mem[pos_rd_addr];
        end
        if (cal_we)
        begin
            cal_mem[chan_reg] <= cal_wr_data;
        end
        if (pos_we)
        begin
            pos_mem[pos_wr_addr] <= pos_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            req_reg       <= req_kind_t'(cmd.req_type);
            chan_reg      <= cmd.channel;
            pulse_min_reg <= cmd.pulse_min;
            pulse_max_reg <= cmd.pulse_max;
            angle_min_reg <= cmd.angle_min;
            angle_max_reg <= cmd.angle_max;
            cont_reg      <= cmd.continuous_rotation;
            preset_reg    <= preset_t'(cmd.preset_select);
            angle_reg     <= cmd.target_angle;
            step_reg      <= cmd.step_ms;
        end
        map_neg_reg <= map_neg_next;
        target_reg  <= target_next;
        result_reg  <= result_next;
        if (out_load)
        begin
            out_reg <= result_reg;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.status        = out_reg.status;
    assign res.write_valid   = out_reg.write_valid;
    assign res.write_channel = out_reg.write_channel;
    assign res.write_value   = out_reg.write_value;
    assign res.busy_res      = out_reg.busy;

    assert property (@(posedge clk) disable iff (!rst_n)
        move_active_reg |-> step_period_reg != '0)
        else $error("A move is active with a zero step period.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (move_active_reg && state_reg == S_IDLE) |-> wait_reg != '0)
        else $error("An active move rests with an expired wait count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_MAPDIV || state_reg == S_STEPDIV))
        else $error("The divider finished while no division was pending.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> state_reg == S_EXEC)
        else $error("An accepted transaction did not enter execution.");

endmodule
`default_nettype wire

// ===== sim/servo_angle_slew_ramp_tb.sv =====
// ============================================================================
// servo_angle_slew_ramp_tb
// Self-checking testbench for the servo slew ramp sequencer. A scoreboard
// class predicts one result transaction per command transaction from its own
// copy of the calibration tables, positions and ramp state. It compares every
// result field by field in order. Stimulus is a short directed part, then
// calibrate, preset, move and tick sequences with random content mixed with
// random noise. The run steps through several tick periods. Both channels
// idle at random, and the result side holds off for long stretches.
// ============================================================================
module servo_angle_slew_ramp_tb;
    import sasr_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 2_000_000;
    localparam int unsigned ITEMS_PER_PHASE = 325;
    localparam int unsigned PHASE_COUNT     = 6;
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam longint      RAMP_TICK_CAP   = 300;

    typedef struct {
        req_kind_t             req;
        logic [CHAN_W-1:0]     channel;
        logic [PULSE_BITS-1:0] pulse_min;
        logic [PULSE_BITS-1:0] pulse_max;
        logic [ANGLE_W-1:0]    angle_min;
        logic [ANGLE_W-1:0]    angle_max;
        logic                  cont;
        preset_t               preset;
        logic [ANGLE_W-1:0]    angle;
        logic [STEP_W-1:0]     step_ms;
    } servo_cmd_t;

    class servo_ramp_scoreboard;
        logic [TICK_W-1:0]   tick_ms;
        bit [PULSE_BITS-1:0] position   [CHANNEL_COUNT];
        bit [PULSE_BITS-1:0] pulse_lo   [CHANNEL_COUNT];
        bit [PULSE_BITS-1:0] pulse_hi   [CHANNEL_COUNT];
        bit [ANGLE_W-1:0]    angle_lo   [CHANNEL_COUNT];
        bit [ANGLE_W-1:0]    angle_hi   [CHANNEL_COUNT];
        bit                  continuous [CHANNEL_COUNT];
        bit                  ramp_active;
        bit [CHAN_W-1:0]     ramp_channel;
        bit [PULSE_BITS-1:0] ramp_target;
        int unsigned         step_ticks;
        int unsigned         ticks_left;
        result_t             awaited_outcomes[$];
        int unsigned         failures;

        function new();
            tick_ms = TICK_PERIOD_RESET;
        endfunction

        function logic [PULSE_BITS-1:0] clamp_pulse(longint v);
            if (v < 0) return '0;
            if (v > PULSE_LIMIT) return PULSE_BITS'(PULSE_LIMIT);
            return PULSE_BITS'(v);
        endfunction

        function logic [PULSE_BITS-1:0] map_angle(logic [CHAN_W-1:0] ch,
                                                  logic [ANGLE_W-1:0] ang);
            longint span_p;
            longint span_a;
            span_p = longint'(pulse_hi[ch]) - longint'(pulse_lo[ch]);
            span_a = longint'(angle_hi[ch]) - longint'(angle_lo[ch]);
            return clamp_pulse((longint'(ang) - longint'(angle_lo[ch])) * span_p / span_a
                               + longint'(pulse_lo[ch]));
        endfunction

        function int unsigned ramp_period(logic [STEP_W-1:0] step_ms);
            int unsigned eff;
            int unsigned per;
            eff = (tick_ms == 0) ? 1 : tick_ms;
            per = step_ms / eff;
            return (per == 0) ? 1 : per;
        endfunction

        function longint move_ticks(servo_cmd_t c);
            longint steps;
            if (ramp_active || c.req != REQ_MOVE) return 0;
            if (angle_lo[c.channel] == angle_hi[c.channel]) return 0;
            steps = longint'(map_angle(c.channel, c.angle)) - longint'(position[c.channel]);
            if (steps < 0) steps = -steps;
            if (steps == 0) return 0;
            return (steps + 1) * ramp_period(c.step_ms);
        endfunction

        function void note_command(servo_cmd_t c);
            result_t             r;
            bit [CHAN_W-1:0]     ch;
            bit [PULSE_BITS-1:0] v;
            r = '0;
            r.status = STATUS_OK;
            ch = c.channel;
            if (c.req == REQ_TICK) begin
                if (ramp_active) begin
                    if (ticks_left > 0) ticks_left--;
                    if (ticks_left == 0) begin
                        if (position[ramp_channel] == ramp_target) begin
                            ramp_active = 1'b0;
                            r.status = STATUS_DONE;
                        end
                        else begin
                            if (position[ramp_channel] < ramp_target)
                                position[ramp_channel]++;
                            else
                                position[ramp_channel]--;
                            ticks_left = step_ticks;
                            r.write_valid = 1'b1;
                            r.write_channel = ramp_channel;
                            r.write_value = position[ramp_channel];
                        end
                    end
                end
            end
            else if (ramp_active) begin
                r.status = STATUS_BUSY;
            end
            else begin
                case (c.req)
                    REQ_CALIBRATE: begin
                        pulse_lo[ch] = c.pulse_min;
                        pulse_hi[ch] = c.pulse_max;
                        angle_lo[ch] = c.angle_min;
                        angle_hi[ch] = c.angle_max;
                        continuous[ch] = c.cont;
                    end
                    REQ_PRESET: begin
                        if (c.preset != PRESET_NONE) begin
                            case (c.preset)
                                PRESET_MIN: v = pulse_lo[ch];
                                PRESET_MAX: v = pulse_hi[ch];
                                default: v = continuous[ch] ? CONT_MIDDLE_PULSE :
                                    clamp_pulse(longint'(pulse_lo[ch]) +
                                        (longint'(pulse_hi[ch]) - longint'(pulse_lo[ch])) / 2);
                            endcase
                            position[ch] = v;
                            r.write_valid = 1'b1;
                            r.write_channel = ch;
                            r.write_value = v;
                        end
                    end
                    default: begin
                        if (angle_lo[ch] == angle_hi[ch]) begin
                            r.status = STATUS_SPAN;
                        end
                        else begin
                            v = map_angle(ch, c.angle);
                            if (v != position[ch]) begin
                                ramp_active = 1'b1;
                                ramp_channel = ch;
                                ramp_target = v;
                                step_ticks = ramp_period(c.step_ms);
                                ticks_left = step_ticks;
                                r.write_valid = 1'b1;
                                r.write_channel = ch;
                                r.write_value = position[ch];
                            end
                        end
                    end
                endcase
            end
            r.busy = ramp_active;
            awaited_outcomes.push_back(r);
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                failures++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited_outcomes.size() == 0) begin
                failures++;
                $display("%0t: unexpected result transaction: expected none, actual %0d/%0d/%0d",
                         $time, got.status, got.write_valid, got.write_value);
                return;
            end
            want = awaited_outcomes.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("write_valid", want.write_valid, got.write_valid);
            compare_field("write_channel", want.write_channel, got.write_channel);
            compare_field("write_value", want.write_value, got.write_value);
            compare_field("busy_res", want.busy, got.busy);
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [TICK_W-1:0] cfg_wr_data;

    sasr_cmd_if cmd_bus ();
    sasr_res_if res_bus ();

    servo_angle_slew_ramp dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_bus),
        .res         (res_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    servo_ramp_scoreboard sb;
    int unsigned          items_sent;
    int unsigned          send_mode = 1;
    int unsigned          take_mode = 1;
    bit                   hold_results;
    int unsigned          cycle_count;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned draw_gap(int unsigned mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 16);
            default: return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 16);
        endcase
    endfunction

    function automatic servo_cmd_t random_command(req_kind_t req);
        servo_cmd_t c;
        c.req = req;
        c.channel = CHAN_W'($urandom_range(0, CHANNEL_COUNT - 1));
        c.pulse_min = PULSE_BITS'($urandom_range(0, PULSE_LIMIT));
        c.pulse_max = PULSE_BITS'($urandom_range(0, PULSE_LIMIT));
        c.angle_min = ANGLE_W'($urandom_range(0, 360));
        c.angle_max = ANGLE_W'($urandom_range(0, 360));
        c.cont = 1'($urandom_range(0, 1));
        c.preset = preset_t'($urandom_range(0, 3));
        c.angle = ANGLE_W'($urandom_range(0, 360));
        c.step_ms = STEP_W'($urandom_range(0, 65535));
        return c;
    endfunction

    function automatic servo_cmd_t tamed(servo_cmd_t c);
        int unsigned eff;
        eff = (sb.tick_ms == 0) ? 1 : sb.tick_ms;
        if (sb.move_ticks(c) > RAMP_TICK_CAP) c.step_ms = STEP_W'($urandom_range(0, eff - 1));
        if (sb.move_ticks(c) > RAMP_TICK_CAP) c.req = REQ_TICK;
        return c;
    endfunction

    task automatic send_command(servo_cmd_t c);
        int unsigned gap;
        gap = draw_gap(send_mode);
        if (gap > 0)
        begin
            cmd_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_bus.req_type = c.req;
        cmd_bus.channel = c.channel;
        cmd_bus.pulse_min = c.pulse_min;
        cmd_bus.pulse_max = c.pulse_max;
        cmd_bus.angle_min = c.angle_min;
        cmd_bus.angle_max = c.angle_max;
        cmd_bus.continuous_rotation = c.cont;
        cmd_bus.preset_select = c.preset;
        cmd_bus.target_angle = c.angle;
        cmd_bus.step_ms = c.step_ms;
        cmd_bus.valid = 1'b1;
        items_sent++;
        do @(posedge clk); while (cmd_bus.ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic send_calibration(logic [CHAN_W-1:0] ch, logic [PULSE_BITS-1:0] pmin,
                                    logic [PULSE_BITS-1:0] pmax, logic [ANGLE_W-1:0] amin,
                                    logic [ANGLE_W-1:0] amax, logic cont);
        servo_cmd_t c;
        c = random_command(REQ_CALIBRATE);
        c.channel = ch;
        c.pulse_min = pmin;
        c.pulse_max = pmax;
        c.angle_min = amin;
        c.angle_max = amax;
        c.cont = cont;
        send_command(c);
    endtask

    task automatic send_preset(logic [CHAN_W-1:0] ch, preset_t sel);
        servo_cmd_t c;
        c = random_command(REQ_PRESET);
        c.channel = ch;
        c.preset = sel;
        send_command(c);
    endtask

    task automatic send_move(logic [CHAN_W-1:0] ch, logic [ANGLE_W-1:0] ang,
                             logic [STEP_W-1:0] step);
        servo_cmd_t c;
        c = random_command(REQ_MOVE);
        c.channel = ch;
        c.angle = ang;
        c.step_ms = step;
        send_command(tamed(c));
    endtask

    task automatic tick_until_idle();
        while (sb.ramp_active)
        begin
            if ($urandom_range(0, 9) == 0)
                send_command(tamed(random_command(req_kind_t'($urandom_range(0, 3)))));
            else
                send_command(random_command(REQ_TICK));
        end
    endtask

    task automatic drain_results(int unsigned extra);
        cmd_bus.valid = 1'b0;
        while (sb.awaited_outcomes.size() != 0) @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic run_directed();
        send_command(random_command(REQ_TICK));
        send_preset(0, PRESET_MID);
        send_move(0, 5, 100);
        send_calibration(15, 4095, 0, 0, 360, 1'b0);
        send_preset(15, PRESET_MIN);
        send_preset(15, PRESET_MID);
        send_preset(15, PRESET_NONE);
        send_preset(15, PRESET_MAX);
        send_calibration(3, 393, 397, 360, 0, 1'b1);
        send_preset(3, PRESET_MID);
        send_move(3, 180, 0);
        send_move(3, 0, 0);
        send_calibration(3, 0, 4095, 360, 360, 1'b1);
        send_move(5, 360, 16'hFFFF);
        tick_until_idle();
        send_calibration(7, 4000, 4095, 0, 1, 1'b0);
        send_preset(7, PRESET_MAX);
        send_move(7, 360, 0);
        send_calibration(8, 0, 4095, 359, 360, 1'b0);
        send_preset(8, PRESET_MIN);
        send_move(8, 0, 0);
        send_calibration(9, 10, 0, 0, 3, 1'b0);
        send_preset(9, PRESET_MIN);
        send_move(9, 1, 25);
        tick_until_idle();
    endtask

    task automatic run_sequence();
        logic [CHAN_W-1:0] ch;
        int                pmin;
        int                pmax;
        int                amin;
        int                amax;
        int unsigned       eff;
        int unsigned       step;
        tick_until_idle();
        ch = CHAN_W'($urandom_range(0, CHANNEL_COUNT - 1));
        if ($urandom_range(0, 3) != 0)
        begin
            pmin = $urandom_range(0, PULSE_LIMIT);
            if ($urandom_range(0, 3) == 0)
                pmax = $urandom_range(0, PULSE_LIMIT);
            else
                pmax = pmin + int'($urandom_range(0, 48)) - 24;
            if (pmax < 0) pmax = 0;
            if (pmax > PULSE_LIMIT) pmax = PULSE_LIMIT;
            amin = $urandom_range(0, 360);
            amax = ($urandom_range(0, 15) == 0) ? amin : $urandom_range(0, 360);
            send_calibration(ch, PULSE_BITS'(pmin), PULSE_BITS'(pmax), ANGLE_W'(amin),
                             ANGLE_W'(amax), 1'($urandom_range(0, 1)));
        end
        send_preset(ch, preset_t'($urandom_range(0, 3)));
        eff = (sb.tick_ms == 0) ? 1 : sb.tick_ms;
        step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3 * eff);
        send_move(ch, ANGLE_W'($urandom_range(sb.angle_lo[ch], sb.angle_hi[ch])),
                  STEP_W'(step));
        tick_until_idle();
    endtask

    always @(posedge clk)
    begin
        servo_cmd_t seen;
        result_t    got;
        if (rst_n === 1'b1)
        begin
            if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
            begin
                got = '0;
                got.status = status_t'(res_bus.status);
                got.write_valid = res_bus.write_valid;
                got.write_channel = res_bus.write_channel;
                got.write_value = res_bus.write_value;
                got.busy = res_bus.busy_res;
                sb.check_result(got);
            end
            if (cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1)
            begin
                seen.req = req_kind_t'(cmd_bus.req_type);
                seen.channel = cmd_bus.channel;
                seen.pulse_min = cmd_bus.pulse_min;
                seen.pulse_max = cmd_bus.pulse_max;
                seen.angle_min = cmd_bus.angle_min;
                seen.angle_max = cmd_bus.angle_max;
                seen.cont = cmd_bus.continuous_rotation;
                seen.preset = preset_t'(cmd_bus.preset_select);
                seen.angle = cmd_bus.target_angle;
                seen.step_ms = cmd_bus.step_ms;
                sb.note_command(seen);
            end
        end
    end

    initial
    begin
        int unsigned stall;
        res_bus.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_results)
            begin
                res_bus.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_results = 1'b0;
            end
            stall = draw_gap(take_mode);
            if (stall > 0)
            begin
                res_bus.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_bus.ready = 1'b1;
            do @(posedge clk); while (res_bus.valid !== 1'b1);
            @(negedge clk);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("servo_angle_slew_ramp regression: fail");
        $finish;
    end

    initial
    begin
        logic [TICK_W-1:0] tick_plan [PHASE_COUNT];
        int unsigned       quota;
        sb = new();
        tick_plan = '{TICK_PERIOD_RESET, 1, 1000, 0, 1023, 0};
        tick_plan[PHASE_COUNT - 1] = TICK_W'($urandom_range(1, 1000));
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        cmd_bus.valid = 1'b0;
        cmd_bus.req_type = REQ_TICK;
        cmd_bus.channel = '0;
        cmd_bus.pulse_min = '0;
        cmd_bus.pulse_max = '0;
        cmd_bus.angle_min = '0;
        cmd_bus.angle_max = '0;
        cmd_bus.continuous_rotation = 1'b0;
        cmd_bus.preset_select = PRESET_MIN;
        cmd_bus.target_angle = '0;
        cmd_bus.step_ms = '0;
        items_sent = 0;
        hold_results = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase > 0)
            begin
                drain_results(4);
                cfg_wr_data = tick_plan[phase];
                cfg_wr_en = 1'b1;
                @(negedge clk);
                cfg_wr_en = 1'b0;
                sb.tick_ms = cfg_wr_data;
            end
            send_mode = phase % 3;
            take_mode = (phase + 1) % 3;
            if (phase == 2 || phase == 4) hold_results = 1'b1;
            quota = items_sent + ITEMS_PER_PHASE;
            while (items_sent < quota)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_command(tamed(random_command(req_kind_t'($urandom_range(0, 3)))));
                else
                    run_sequence();
            end
            tick_until_idle();
        end
        drain_results(60);

        if (sb.failures == 0 && sb.awaited_outcomes.size() == 0)
            $display("servo_angle_slew_ramp regression: pass");
        else
            $display("servo_angle_slew_ramp regression: fail");
        $finish;
    end

endmodule
